FILE: rtl/core/mte_pkg.sv
// mte_pkg: shared types, character codes and helpers for the markup text extractor
// used by mte_scan, mte_out_fifo and markup_text_extractor_top; no dependencies
package mte_pkg;

    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_NUL   = 8'h00;

    // tag names, oldest byte in the top bits
    localparam logic [55:0] OPEN_SCRIPT  = "<script";
    localparam logic [47:0] OPEN_STYLE   = "<style";
    localparam logic [63:0] CLOSE_SCRIPT = "</script";
    localparam logic [55:0] CLOSE_STYLE  = "</style";

    localparam int unsigned WIN_DEPTH   = 8;
    localparam logic [3:0]  SEEN_MAX    = 4'd9;
    localparam logic [3:0]  SEEN_SCRIPT = 4'd9;
    localparam logic [3:0]  SEEN_STYLE  = 4'd7;
    localparam int unsigned OUT_DEPTH   = 4;

    typedef struct packed {
        logic [7:0] out_char;
        logic       run_last;
    } ent_t;

    // results of one byte: cnt words, ent0 first
    typedef struct packed {
        logic [1:0] cnt;
        ent_t       ent0;
        ent_t       ent1;
    } res_t;

    function automatic logic [7:0] fold_case(input logic [7:0] b);
        logic [7:0] r;
        r = b;
        if (b >= 8'h41 && b <= 8'h5A)
        begin
            r = b + 8'd32;
        end
        return r;
    endfunction

    function automatic logic is_white(input logic [7:0] b);
        return (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
    endfunction

endpackage

FILE: rtl/core/mte_scan.sv
// mte_scan: per-byte tag/script/style tracking, whitespace collapsing and result forming
// depends on mte_pkg
module mte_scan (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            fire,
    input  logic [7:0]      text_byte,
    input  logic            end_of_text,
    output mte_pkg::res_t   res
);

    logic [7:0] win_reg [mte_pkg::WIN_DEPTH];
    logic [7:0] fw [mte_pkg::WIN_DEPTH];
    logic [3:0] seen_reg;
    logic       tag_reg;
    logic       script_reg;
    logic       style_reg;
    logic       pend_reg;
    logic       emitted_reg;

    logic       tag_next;
    logic       script_next;
    logic       style_next;
    logic       pend_next;
    logic       emitted_next;

    logic       is_lt;
    logic       is_gt;
    logic       is_sp;
    logic       hit_open_script;
    logic       hit_open_style;
    logic       hit_close_script;
    logic       hit_close_style;
    logic       script_mid;
    logic       style_mid;

    always_comb
    begin
        for (int i = 0; i < mte_pkg::WIN_DEPTH; i++)
        begin
            fw[i] = mte_pkg::fold_case(win_reg[i]);
        end
    end

    assign is_lt = (text_byte == mte_pkg::CH_LT);
    assign is_gt = (text_byte == mte_pkg::CH_GT);
    assign is_sp = (text_byte == mte_pkg::CH_SPACE);

    assign hit_open_script  = ({fw[6], fw[5], fw[4], fw[3], fw[2], fw[1], fw[0]}
                               == mte_pkg::OPEN_SCRIPT);
    assign hit_open_style   = ({fw[5], fw[4], fw[3], fw[2], fw[1], fw[0]}
                               == mte_pkg::OPEN_STYLE);
    assign hit_close_script = ({fw[7], fw[6], fw[5], fw[4], fw[3], fw[2], fw[1], fw[0]}
                               == mte_pkg::CLOSE_SCRIPT);
    assign hit_close_style  = ({fw[6], fw[5], fw[4], fw[3], fw[2], fw[1], fw[0]}
                               == mte_pkg::CLOSE_STYLE);

    // opening check comes before the byte itself is handled
    assign script_mid = script_reg | ((is_gt | is_sp) & hit_open_script);
    assign style_mid  = style_reg  | ((is_gt | is_sp) & hit_open_style);

    always_comb
    begin
        tag_next     = tag_reg;
        script_next  = script_mid;
        style_next   = style_mid;
        pend_next    = pend_reg;
        emitted_next = emitted_reg;
        res          = '0;
        priority if (is_lt)
        begin
            tag_next = 1'b1;
        end
        else if (is_gt)
        begin
            tag_next = 1'b0;
            if (script_mid && seen_reg >= mte_pkg::SEEN_SCRIPT && hit_close_script)
            begin
                script_next = 1'b0;
            end
            if (style_mid && seen_reg >= mte_pkg::SEEN_STYLE && hit_close_style)
            begin
                style_next = 1'b0;
            end
        end
        else if (text_byte != mte_pkg::CH_NUL && !tag_reg && !script_mid && !style_mid)
        begin
            if (mte_pkg::is_white(text_byte))
            begin
                if (emitted_reg)
                begin
                    pend_next = 1'b1;
                end
            end
            else
            begin
                emitted_next = 1'b1;
                pend_next    = 1'b0;
                if (pend_reg)
                begin
                    res.cnt           = 2'd2;
                    res.ent0.out_char = mte_pkg::CH_SPACE;
                    res.ent0.run_last = 1'b0;
                    res.ent1.out_char = text_byte;
                    res.ent1.run_last = 1'b1;
                end
                else
                begin
                    res.cnt           = 2'd1;
                    res.ent0.out_char = text_byte;
                    res.ent0.run_last = 1'b1;
                end
            end
        end
        else
        begin
            // zero byte or suppressed byte: no words
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < mte_pkg::WIN_DEPTH; i++)
            begin
                win_reg[i] <= '0;
            end
            seen_reg    <= '0;
            tag_reg     <= 1'b0;
            script_reg  <= 1'b0;
            style_reg   <= 1'b0;
            pend_reg    <= 1'b0;
            emitted_reg <= 1'b0;
        end
        else if (fire)
        begin
            if (end_of_text)
            begin
                // document ends: everything back to reset, pending space dropped
                for (int i = 0; i < mte_pkg::WIN_DEPTH; i++)
                begin
                    win_reg[i] <= '0;
                end
                seen_reg    <= '0;
                tag_reg     <= 1'b0;
                script_reg  <= 1'b0;
                style_reg   <= 1'b0;
                pend_reg    <= 1'b0;
                emitted_reg <= 1'b0;
            end
            else
            begin
                for (int i = mte_pkg::WIN_DEPTH - 1; i > 0; i--)
                begin
                    win_reg[i] <= win_reg[i-1];
                end
                win_reg[0] <= text_byte;
                if (seen_reg < mte_pkg::SEEN_MAX)
                begin
                    seen_reg <= seen_reg + 4'd1;
                end
                tag_reg     <= tag_next;
                script_reg  <= script_next;
                style_reg   <= style_next;
                pend_reg    <= pend_next;
                emitted_reg <= emitted_next;
            end
        end
    end

    a_pair_starts_with_space: assert property (@(posedge clk) disable iff (!rst_n)
        (res.cnt == 2'd2) |-> (res.ent0.out_char == mte_pkg::CH_SPACE && !res.ent0.run_last))
        else $error("two results without a leading space");

    a_doc_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && end_of_text) |=> (seen_reg == 4'd0 && !emitted_reg && !pend_reg))
        else $error("state not cleared after end of text");

    a_pending_needs_emit: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> emitted_reg)
        else $error("space pending before any visible byte");

    a_seen_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        seen_reg <= mte_pkg::SEEN_MAX)
        else $error("byte count beyond saturation");

endmodule

FILE: rtl/core/mte_out_fifo.sv
// mte_out_fifo: small queue, up to two words in per cycle, one out per unstalled cycle
// depends on mte_pkg
module mte_out_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  mte_pkg::res_t   res,
    output logic            room,
    output logic            out_valid,
    input  logic            out_stall,
    output logic [7:0]      out_char,
    output logic            run_last
);

    localparam int unsigned PTR_W = $clog2(mte_pkg::OUT_DEPTH);
    localparam int unsigned CNT_W = $clog2(mte_pkg::OUT_DEPTH + 1);

    mte_pkg::ent_t     mem_reg [mte_pkg::OUT_DEPTH];
    logic [PTR_W-1:0]  wr_reg;
    logic [PTR_W-1:0]  rd_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic [1:0]        push_n;
    logic              pop;

    assign push_n    = push ? res.cnt : 2'd0;
    assign pop       = out_valid && !out_stall;
    assign out_valid = (cnt_reg != '0);
    assign out_char  = mem_reg[rd_reg].out_char;
    assign run_last  = mem_reg[rd_reg].run_last;
    // two free words before the next byte may go through
    assign room      = (cnt_reg <= CNT_W'(mte_pkg::OUT_DEPTH - 2));
    assign cnt_next  = cnt_reg + CNT_W'(push_n) - CNT_W'(pop);

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            mem_reg[wr_reg] <= res.ent0;
        end
        if (push_n == 2'd2)
        begin
            mem_reg[wr_reg + PTR_W'(1)] <= res.ent1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_reg + PTR_W'(push_n);
            rd_reg  <= rd_reg + PTR_W'(pop);
            cnt_reg <= cnt_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (push_n != 2'd0) |-> room)
        else $error("result queue written without room");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(mte_pkg::OUT_DEPTH))
        else $error("result queue count out of range");

    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (cnt_reg == $past(cnt_next)))
        else $error("result queue count mismatch");

endmodule

FILE: rtl/core/markup_text_extractor_top.sv
// markup_text_extractor_top: streams markup bytes in, visible text words out
// depends on mte_pkg, mte_scan and mte_out_fifo
//
// input channel: in_valid/in_stall with text_byte and end_of_text; a byte is taken on
// a rising edge with in_valid high and in_stall low. end_of_text marks the last byte
// of a document, after which all scanner state returns to its reset value.
// output channel: out_valid/out_stall with out_char and run_last; each input byte yields
// zero, one or two words (a collapsed space, then the visible byte); run_last is set
// on the last word a byte produced.
// order: a byte is loaded into the input register when it is accepted, and its words
// are written into the result queue when the held byte fires, which needs room in the
// queue; the first word is then offered on the output from the queue.
// throughput: one byte per cycle while the receiver keeps up; bytes yielding two words
// are bounded by the single output port at one word per cycle, and the four-word
// result queue lets the next byte through only while two words of room remain.
// receiver stall: words wait in the queue; once fewer than two words of room remain,
// in_stall rises while a byte is held and the input register keeps that byte.
// reset: rst_n is asynchronous, empties the queue and clears all scanner state.
module markup_text_extractor_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  text_byte,
    input  logic        end_of_text,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_char,
    output logic        run_last
);

    logic           in_vld_reg;
    logic [7:0]     byte_reg;
    logic           eot_reg;
    logic           room;
    logic           fire;
    logic           take;
    mte_pkg::res_t  res;

    assign fire     = in_vld_reg && room;
    assign in_stall = in_vld_reg && !room;
    assign take     = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg <= take || (in_vld_reg && !fire);
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            byte_reg <= text_byte;
            eot_reg  <= end_of_text;
        end
    end

    mte_scan u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .text_byte   (byte_reg),
        .end_of_text (eot_reg),
        .res         (res)
    );

    mte_out_fifo u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fire),
        .res       (res),
        .room      (room),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_char  (out_char),
        .run_last  (run_last)
    );

    a_held_byte_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (in_vld_reg && !fire) |=> (in_vld_reg && $stable(byte_reg) && $stable(eot_reg)))
        else $error("held input byte changed before processing");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (in_vld_reg && !room))
        else $error("input stalled with room available");

    a_no_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (!in_vld_reg && !out_valid) |=> !out_valid || $past(fire))
        else $error("result appeared without a processed byte");

endmodule
